// ----- design/snfs_pkg.sv -----
// Shared types, opcodes and sizing constants for the SPI NOR flash sequencer.
package snfs_pkg;

  // Program pages; the page size must be a power of two.
  localparam int unsigned PageBytes = 256;
  localparam int unsigned PageBits  = $clog2(PageBytes);
  localparam int unsigned ChunkW    = PageBits + 1;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CmdRequest  = 2'd0,
    CmdPayload  = 2'd1,
    CmdReceived = 2'd2,
    CmdUnused   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OpRead        = 2'd0,
    OpProgram     = 2'd1,
    OpSectorErase = 2'd2,
    OpChipErase   = 2'd3
  } op_e;

  localparam logic [7:0] OpcWriteEnable = 8'h06;
  localparam logic [7:0] OpcReadStatus  = 8'h05;
  localparam logic [7:0] OpcRead        = 8'h03;
  localparam logic [7:0] OpcPageProgram = 8'h02;
  localparam logic [7:0] OpcSectorErase = 8'h20;
  localparam logic [7:0] OpcChipErase   = 8'hC7;
  localparam logic [7:0] StatusWip      = 8'h01;
  localparam logic [7:0] DummyByte      = 8'hFF;

  typedef enum logic [10:0] {
    PhIdle       = 11'b000_0000_0001,
    PhWren       = 11'b000_0000_0010,
    PhHdr        = 11'b000_0000_0100,
    PhRead       = 11'b000_0000_1000,
    PhProgWant   = 11'b000_0001_0000,
    PhProgSent   = 11'b000_0010_0000,
    PhStatCmd    = 11'b000_0100_0000,
    PhStat       = 11'b000_1000_0000,
    PhEraseCmd   = 11'b001_0000_0000,
    PhPreStatCmd = 11'b010_0000_0000,
    PhPreStat    = 11'b100_0000_0000
  } phase_e;

  // Item kinds after classification in the front end.
  typedef enum logic [1:0] {
    KindRequest  = 2'd0,
    KindPayload  = 2'd1,
    KindReceived = 2'd2,
    KindNone     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  operation;
    logic [23:0] flash_address;
    logic [15:0] byte_count;
    logic [7:0]  payload_byte;
    logic [7:0]  received_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] send_byte;
    logic       send_valid;
    logic       frame_end;
    logic [7:0] data_out;
    logic       data_out_valid;
    logic       want_payload;
    logic       finished;
  } out_item_t;

  // Classified item held in the queue; payload and received bytes share one field.
  typedef struct packed {
    kind_e       kind;
    op_e         operation;
    logic [23:0] flash_address;
    logic [15:0] byte_count;
    logic [7:0]  data;
  } entry_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- design/spi_nor_flash_sequencer.sv -----
// Top level of the SPI NOR flash sequencer: front end, queue and back end.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// One input transfer per cycle is sustained while out_stall_i is low; the
// two-entry queue sets the input stall, which rises only while both entries
// are occupied. A result passes through the queue entry and then the
// registered result stage after its input transfer. Misplaced items that
// produce no result are still popped by the sequencer; unused commands are
// dropped in the front end and never reach it.
// The sequencer advances only when the result stage is empty or drains in the
// same cycle, so out_stall_i holds back the queue and then the input side.
// rst_ni clears the queue, the phase (back to idle) and the result stage.
module spi_nor_flash_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  snfs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output snfs_pkg::out_item_t out_data_o
);
  import snfs_pkg::*;

  queue_stat_t qstat;
  logic        push;
  logic        pop;
  entry_t      entry;
  entry_t      head;

  // Classify incoming transfers and drop unused commands before queuing.
  snfs_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (entry)
  );

  // Decouple input acceptance from output stalls.
  snfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // Run the frame sequence: opcode, address, data, status polling.
  snfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- design/snfs_front.sv -----
// Front end: accepts input transfers, classifies them and drops unused commands.
module snfs_front (
  input  logic                 in_valid_i,
  input  snfs_pkg::in_item_t   in_data_i,
  output logic                 in_stall_o,
  input  snfs_pkg::queue_stat_t qstat_i,
  output logic                 push_o,
  output snfs_pkg::entry_t     entry_o
);
  import snfs_pkg::*;

  kind_e kind;

  always_comb begin
    case (in_data_i.command)
      CmdRequest:  kind = KindRequest;
      CmdPayload:  kind = KindPayload;
      CmdReceived: kind = KindReceived;
      default:     kind = KindNone;
    endcase
  end

  assign in_stall_o = qstat_i.full;

  // Drop unused commands here; they never reach the sequencer.
  assign push_o = in_valid_i && !qstat_i.full && (kind != KindNone);

  always_comb begin
    entry_o.kind          = kind;
    entry_o.operation     = op_e'(in_data_i.operation);
    entry_o.flash_address = in_data_i.flash_address;
    entry_o.byte_count    = in_data_i.byte_count;
    entry_o.data          = (kind == KindPayload) ? in_data_i.payload_byte
                                                  : in_data_i.received_byte;
  end

endmodule

// ----- design/snfs_queue.sv -----
// Two-entry queue between the front end and the sequencer back end.
module snfs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  snfs_pkg::entry_t      entry_i,
  input  logic                  pop_i,
  output snfs_pkg::entry_t      head_o,
  output snfs_pkg::queue_stat_t qstat_o
);
  import snfs_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (count_q == CntW'(QueueDepth));
  assign qstat_o.empty = (count_q == '0);

endmodule

// ----- design/snfs_back.sv -----
// Back end: frame sequencer state machine and the registered result stage.
module snfs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  snfs_pkg::entry_t      head_i,
  input  snfs_pkg::queue_stat_t qstat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output snfs_pkg::out_item_t   out_data_o
);
  import snfs_pkg::*;

  phase_e             phase_q, phase_d;
  op_e                op_q, op_d;
  logic [23:0]        addr_q, addr_d;
  logic [15:0]        total_q, total_d;
  logic [ChunkW-1:0]  chunk_q, chunk_d;
  logic [1:0]         hdr_q, hdr_d;

  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  out_item_t          res;
  logic               res_vld;
  logic [15:0]        total_dec;
  logic [ChunkW-1:0]  chunk_dec;
  logic [ChunkW-1:0]  room;
  logic [7:0]         hdr_byte;
  logic               is_rx;

  function automatic out_item_t send_item(logic [7:0] b, logic fe);
    out_item_t o;
    o            = '0;
    o.send_byte  = b;
    o.send_valid = 1'b1;
    o.frame_end  = fe;
    return o;
  endfunction

  // Pop whenever the result stage is free or drains this cycle.
  assign pop_o = !qstat_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    total_dec = (total_q != '0) ? total_q - 16'd1 : total_q;
    chunk_dec = chunk_q - 1'b1;
    room      = ChunkW'(PageBytes) - {1'b0, addr_q[PageBits-1:0]};
    is_rx     = (head_i.kind == KindReceived);
    case (hdr_q)
      2'd0:    hdr_byte = addr_q[23:16];
      2'd1:    hdr_byte = addr_q[15:8];
      default: hdr_byte = addr_q[7:0];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    addr_d  = addr_q;
    total_d = total_q;
    chunk_d = chunk_q;
    hdr_d   = hdr_q;
    res     = '0;
    res_vld = 1'b0;

    case (phase_q)
      PhIdle: begin
        if (head_i.kind == KindRequest) begin
          op_d    = head_i.operation;
          addr_d  = head_i.flash_address;
          total_d = head_i.byte_count;
          chunk_d = '0;
          hdr_d   = '0;
          res_vld = 1'b1;
          if (head_i.operation == OpRead) begin
            phase_d = PhHdr;
            res     = send_item(OpcRead, 1'b0);
          end else if (head_i.operation == OpProgram && head_i.byte_count == '0) begin
            res.finished = 1'b1;
          end else begin
            phase_d = PhWren;
            res     = send_item(OpcWriteEnable, 1'b1);
          end
        end
      end

      PhProgWant: begin
        if (head_i.kind == KindPayload && chunk_q != '0) begin
          chunk_d = chunk_dec;
          total_d = total_dec;
          addr_d  = addr_q + 24'd1;
          phase_d = PhProgSent;
          res_vld = 1'b1;
          res     = send_item(head_i.data, chunk_dec == '0);
        end
      end

      PhWren: begin
        if (is_rx) begin
          res_vld = 1'b1;
          case (op_q)
            OpProgram: begin
              chunk_d = ({1'b0, total_q} < 17'(room)) ? ChunkW'(total_q) : room;
              phase_d = PhHdr;
              hdr_d   = '0;
              res     = send_item(OpcPageProgram, 1'b0);
            end
            OpSectorErase: begin
              phase_d = PhPreStatCmd;
              res     = send_item(OpcReadStatus, 1'b0);
            end
            OpChipErase: begin
              phase_d = PhEraseCmd;
              res     = send_item(OpcChipErase, 1'b1);
            end
            default: begin
              phase_d      = PhIdle;
              hdr_d        = '0;
              res.finished = 1'b1;
            end
          endcase
        end
      end

      PhPreStatCmd: begin
        if (is_rx) begin
          phase_d = PhPreStat;
          res_vld = 1'b1;
          res     = send_item(DummyByte, 1'b1);
        end
      end

      PhPreStat: begin
        if (is_rx) begin
          res_vld = 1'b1;
          if ((head_i.data & StatusWip) != '0) begin
            phase_d = PhPreStatCmd;
            res     = send_item(OpcReadStatus, 1'b0);
          end else begin
            phase_d = PhHdr;
            hdr_d   = '0;
            res     = send_item(OpcSectorErase, 1'b0);
          end
        end
      end

      PhEraseCmd: begin
        if (is_rx) begin
          phase_d = PhStatCmd;
          res_vld = 1'b1;
          res     = send_item(OpcReadStatus, 1'b0);
        end
      end

      PhHdr: begin
        if (is_rx) begin
          res_vld = 1'b1;
          if (hdr_q != 2'd3) begin
            hdr_d = hdr_q + 2'd1;
            res   = send_item(hdr_byte, (hdr_q == 2'd2) &&
                              ((op_q == OpRead && total_q == '0) || op_q == OpSectorErase));
          end else begin
            hdr_d = '0;
            case (op_q)
              OpRead: begin
                if (total_q == '0) begin
                  phase_d      = PhIdle;
                  res.finished = 1'b1;
                end else begin
                  phase_d = PhRead;
                  res     = send_item(DummyByte, total_q == 16'd1);
                end
              end
              OpProgram: begin
                phase_d          = PhProgWant;
                res.want_payload = 1'b1;
              end
              OpSectorErase: begin
                phase_d = PhStatCmd;
                res     = send_item(OpcReadStatus, 1'b0);
              end
              default: begin
                phase_d      = PhIdle;
                res.finished = 1'b1;
              end
            endcase
          end
        end
      end

      PhRead: begin
        if (is_rx) begin
          total_d            = total_dec;
          res_vld            = 1'b1;
          if (total_dec == '0) begin
            phase_d      = PhIdle;
            res.finished = 1'b1;
          end else begin
            res = send_item(DummyByte, total_dec == 16'd1);
          end
          res.data_out       = head_i.data;
          res.data_out_valid = 1'b1;
        end
      end

      PhProgSent: begin
        if (is_rx) begin
          res_vld = 1'b1;
          if (chunk_q != '0) begin
            phase_d          = PhProgWant;
            res.want_payload = 1'b1;
          end else begin
            phase_d = PhStatCmd;
            res     = send_item(OpcReadStatus, 1'b0);
          end
        end
      end

      PhStatCmd: begin
        if (is_rx) begin
          phase_d = PhStat;
          res_vld = 1'b1;
          res     = send_item(DummyByte, 1'b1);
        end
      end

      PhStat: begin
        if (is_rx) begin
          res_vld = 1'b1;
          if ((head_i.data & StatusWip) != '0) begin
            phase_d = PhStatCmd;
            res     = send_item(OpcReadStatus, 1'b0);
          end else if (op_q == OpProgram && total_q != '0) begin
            phase_d = PhWren;
            res     = send_item(OpcWriteEnable, 1'b1);
          end else begin
            phase_d      = PhIdle;
            hdr_d        = '0;
            res.finished = 1'b1;
          end
        end
      end

      default: begin
        phase_d = PhIdle;
        hdr_d   = '0;
      end
    endcase
  end

  // Result stage: load on pop, clear once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop_o) begin
      out_valid_d = res_vld;
      out_d       = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      op_q        <= OpRead;
      addr_q      <= '0;
      total_q     <= '0;
      chunk_q     <= '0;
      hdr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        op_q    <= op_d;
        addr_q  <= addr_d;
        total_q <= total_d;
        chunk_q <= chunk_d;
        hdr_q   <= hdr_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_finish_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res_vld && res.finished) |=> (phase_q == PhIdle))
    else $error("finished result without returning to idle");

  a_chunk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chunk_q <= ChunkW'(PageBytes)))
    else $error("chunk count exceeds page size");

  a_want_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhProgWant) |-> (chunk_q != '0))
    else $error("payload requested with empty chunk");

  a_no_stray_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.send_valid) |-> (!out_q.frame_end && out_q.send_byte == '0))
    else $error("frame end or byte without a send");
`endif

endmodule
